// ----- hw/rtl/fdh_pkg.sv -----
// ----------------------------------------------------------------------------
// fdh_pkg: shared constants and types for the flood duplicate filter
// Hash constants, ring geometry and the request/result bundles between units.
// ----------------------------------------------------------------------------
package fdh_pkg;

    localparam int CACHE_ENTRIES = 128;
    localparam int HASH_W        = 32;
    localparam int BYTE_W        = 8;
    localparam int HASH_SHIFT    = 5;
    localparam int RING_AW       = $clog2(CACHE_ENTRIES);
    localparam int FILL_W        = $clog2(CACHE_ENTRIES + 1);

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

    // Finished hash handed from the hash unit to the ring controller
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } req_t;

    // Verdict handed from the ring controller to the top level
    typedef struct packed {
        logic              valid;
        logic              dup;
        logic [HASH_W-1:0] hash;
    } res_t;

endpackage

// ----- hw/rtl/fdh_ram.sv -----
// ----------------------------------------------------------------------------
// fdh_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/fdh_hash.sv -----
// ----------------------------------------------------------------------------
// fdh_hash: running djb2 hash accumulator
// Fold one byte per transfer; hand off the finished hash on the last byte.
// ----------------------------------------------------------------------------
module fdh_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [fdh_pkg::BYTE_W-1:0] msg_byte,
    input  logic                      end_of_msg,
    output fdh_pkg::req_t             req
);

    logic [fdh_pkg::HASH_W-1:0] running_hash_reg;
    logic [fdh_pkg::HASH_W-1:0] running_hash_next;
    logic [fdh_pkg::HASH_W-1:0] folded;

    // hash * 33 + byte, wrapping
    assign folded = (running_hash_reg << fdh_pkg::HASH_SHIFT) + running_hash_reg
                  + {{(fdh_pkg::HASH_W - fdh_pkg::BYTE_W){1'b0}}, msg_byte};

    always_comb
    begin
        running_hash_next = running_hash_reg;
        if (accept)
        begin
            running_hash_next = end_of_msg ? fdh_pkg::HASH_SEED : folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= fdh_pkg::HASH_SEED;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
        end
    end

    assign req.valid = accept & end_of_msg;
    assign req.hash  = folded;

endmodule

// ----- hw/rtl/fdh_ring.sv -----
// ----------------------------------------------------------------------------
// fdh_ring: ring search and store controller
// Scan the filled ring entries one per cycle, then report or store the hash.
// ----------------------------------------------------------------------------
module fdh_ring (
    input  logic          clk,
    input  logic          rst_n,
    input  fdh_pkg::req_t req,
    output logic          busy,
    output fdh_pkg::res_t res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;

    logic [1:0]                  state_reg,   state_next;
    logic [fdh_pkg::HASH_W-1:0]  key_reg,     key_next;
    logic [fdh_pkg::FILL_W-1:0]  idx_reg,     idx_next;
    logic                        cmp_vld_reg, cmp_vld_next;
    logic [fdh_pkg::FILL_W-1:0]  fill_reg,    fill_next;
    logic [fdh_pkg::RING_AW-1:0] ptr_reg,     ptr_next;
    fdh_pkg::res_t               res_reg,     res_next;

    logic                        hit;
    logic                        more;
    logic                        rd_en;
    logic                        wr_en;
    logic [fdh_pkg::HASH_W-1:0]  rd_data;

    // Entries at or past the fill count were never written: never read them
    assign more  = idx_reg < fill_reg;
    assign hit   = (state_reg == ST_SCAN) && cmp_vld_reg && (rd_data == key_reg)
                 && (key_reg != '0);
    assign rd_en = (state_reg == ST_SCAN) && more && !hit;
    assign wr_en = (state_reg == ST_SCAN) && !more && !hit;

    always_comb
    begin
        state_next   = state_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        cmp_vld_next = rd_en;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        res_next     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    key_next   = req.hash;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    idx_next = idx_reg + fdh_pkg::FILL_W'(1);
                end
                if (hit)
                begin
                    res_next   = '{valid: 1'b1, dup: 1'b1, hash: key_reg};
                    state_next = ST_IDLE;
                end
                else if (wr_en)
                begin
                    res_next = '{valid: 1'b1, dup: 1'b0, hash: key_reg};
                    if (ptr_reg == fdh_pkg::RING_AW'(fdh_pkg::CACHE_ENTRIES - 1))
                    begin
                        ptr_next = '0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + fdh_pkg::RING_AW'(1);
                    end
                    if (fill_reg != fdh_pkg::FILL_W'(fdh_pkg::CACHE_ENTRIES))
                    begin
                        fill_next = fill_reg + fdh_pkg::FILL_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            fill_reg    <= '0;
            ptr_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            fill_reg    <= fill_next;
            ptr_reg     <= ptr_next;
            res_reg     <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    fdh_ram #(
        .WIDTH (fdh_pkg::HASH_W),
        .DEPTH (fdh_pkg::CACHE_ENTRIES)
    ) u_ring_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ptr_reg),
        .wdata (key_reg),
        .re    (rd_en),
        .raddr (idx_reg[fdh_pkg::RING_AW-1:0]),
        .rdata (rd_data)
    );

    assign busy = (state_reg != ST_IDLE);
    assign res  = res_reg;

    // Fill count never exceeds the ring size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= fdh_pkg::FILL_W'(fdh_pkg::CACHE_ENTRIES))
        else $error("fill count beyond ring size");

    // No read left in flight once the controller is idle
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !cmp_vld_reg)
        else $error("ring read outstanding while idle");

    // A result always closes the search and frees the controller
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid |-> state_reg == ST_IDLE)
        else $error("result while still searching");

    // A store moves the pointer by one entry, with wrap
    a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (ptr_reg == $past(ptr_reg) + fdh_pkg::RING_AW'(1))
               || (ptr_reg == '0))
        else $error("ring pointer did not advance on store");

endmodule

// ----- hw/rtl/flood_dedup_hash_cache_top.sv -----
// ----------------------------------------------------------------------------
// flood_dedup_hash_cache_top: duplicate filter for flooded mesh messages
// Hash message bytes with djb2 and check the result against a ring of recent
// message hashes; report duplicates, store new hashes.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  byte in  | start & !busy        | msg_byte[7:0], end_of_msg
//  verdict  | done (one-cycle)     | is_duplicate, digest[31:0]
//
//  A byte without the end mark is folded into the hash and the next may follow at once.
//  A final byte raises busy while the ring is scanned one entry per cycle over
//  the F entries written so far (F <= CACHE_ENTRIES): done strobes when the scan
//  ends, on a hit or after the last entry, and busy falls in that same cycle.
//  Reset clears the hash, ring pointer and fill count; the ring memory itself
//  is not cleared, since entries past the fill count are never read.
//  The receiver cannot stall: done is high for exactly one cycle.
//
module flood_dedup_hash_cache_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fdh_pkg::BYTE_W-1:0]   msg_byte,
    input  logic                         end_of_msg,
    output logic                         done,
    output logic                         is_duplicate,
    output logic [fdh_pkg::HASH_W-1:0]   digest
);

    logic          accept;
    fdh_pkg::req_t req;
    fdh_pkg::res_t res;

    // Take a byte whenever the ring controller is free
    assign accept = start & ~busy;

    fdh_hash u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .msg_byte   (msg_byte),
        .end_of_msg (end_of_msg),
        .req        (req)
    );

    fdh_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .busy  (busy),
        .res   (res)
    );

    // Drive the verdict straight from the controller's output register
    assign done         = res.valid;
    assign is_duplicate = res.dup;
    assign digest       = res.hash;

endmodule
